// ===== rtl/bcat_pkg.sv =====
package bcat_pkg;

  localparam int TABLE_BLOCKS     = 64;
  localparam int FIRST_DATA_BLOCK = 5;
  localparam int BLK_W            = $clog2(TABLE_BLOCKS);
  localparam int STEP_W           = $clog2(TABLE_BLOCKS + 1);
  localparam int LINK_W           = 16;

  localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;
  localparam logic [BLK_W-1:0]  MAX_FREE = BLK_W'(TABLE_BLOCKS - FIRST_DATA_BLOCK);
  localparam logic [BLK_W-1:0]  LAST_RESET = BLK_W'(FIRST_DATA_BLOCK - 1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_FORMAT = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_RANGE     = 2'd2,
    ST_BAD_COUNT = 2'd3
  } op_status_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [BLK_W-1:0] block_count;
    logic [BLK_W-1:0] start_block;
    logic [BLK_W-1:0] position;
  } req_t;

  typedef struct packed {
    op_status_t      status;
    logic [BLK_W-1:0] block;
    logic [BLK_W-1:0] free_blocks;
    logic [BLK_W-1:0] last_allocated;
  } rsp_t;

endpackage

// ===== rtl/block_chain_allocation_table.sv =====
// Linked block-chain allocation table.
// Request channel (req_valid, req_stall, req): one item is one operation:
// allocate a chain of the lowest free blocks, free a chain, find the nth
// block of a chain, or format the table. req_stall stays high from the
// cycle after an item is taken until its result has been loaded into the
// response register, so one operation is in progress at a time.
// Response channel (rsp_valid, rsp_stall, rsp): one item per request, held
// in an output register until taken; a new request is accepted while a
// result still waits there, and the block waits in its final step only when
// a second result is ready before the first one is taken.
// Format and rejected requests go straight to the final step. Allocate scans
// the free flags one block per cycle twice, once to count and once to link.
// Free does one table read and then one update per chain link; lookup reads
// one link per step. The link table has a single read port.
// Reset (synchronous, rst high) marks every block free, sets the free count
// to TABLE_BLOCKS - FIRST_DATA_BLOCK and empties the response register;
// format has the same effect on the table.
module block_chain_allocation_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bcat_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bcat_pkg::rsp_t rsp
);
  import bcat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_COUNT,
    S_A_LINK,
    S_A_END,
    S_F_READ,
    S_F_STEP,
    S_F_FIN,
    S_L_CHECK,
    S_L_STEP,
    S_DONE
  } state_t;

  state_t                state;
  logic [STEP_W-1:0]     cur;
  logic [STEP_W-1:0]     cnt;
  logic [BLK_W-1:0]      target;
  logic [BLK_W-1:0]      prev;
  logic [BLK_W-1:0]      first;
  logic [BLK_W-1:0]      free_count;
  logic [BLK_W-1:0]      last_slot;
  op_status_t            res_status;
  logic [BLK_W-1:0]      res_block;
  logic [TABLE_BLOCKS-1:0] used;

  logic [LINK_W-1:0]     mem [TABLE_BLOCKS];
  logic [LINK_W-1:0]     rdata;
  logic [LINK_W-1:0]     entry;
  logic                  mem_we;
  logic [BLK_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;
  logic [BLK_W-1:0]      cur_idx;
  logic [STEP_W:0]       free_sum;
  logic                  link_hit;

  function automatic logic is_data(input logic [LINK_W-1:0] v);
    return (v >= LINK_W'(FIRST_DATA_BLOCK)) && (v < LINK_W'(TABLE_BLOCKS));
  endfunction

  assign cur_idx   = cur[BLK_W-1:0];
  assign entry     = used[cur_idx] ? rdata : '0;
  assign free_sum  = (STEP_W+1)'(free_count) + (STEP_W+1)'(cnt);
  assign req_stall = (state != S_IDLE);
  assign link_hit  = (cnt != STEP_W'(target)) && !used[cur_idx];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prev;
    mem_wdata = END_MARK;
    case (state)
      S_A_LINK: begin
        if (link_hit && cnt != '0) begin
          mem_we    = 1'b1;
          mem_wdata = LINK_W'(cur_idx);
        end
      end
      S_A_END: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      used       <= '0;
      free_count <= MAX_FREE;
      last_slot  <= LAST_RESET;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_block <= '0;
            unique case (req.kind)
              OP_ALLOC: begin
                if (req.block_count == '0) begin
                  res_status <= ST_BAD_COUNT;
                  state      <= S_DONE;
                end else if (free_count < req.block_count) begin
                  res_status <= ST_NO_SPACE;
                  state      <= S_DONE;
                end else begin
                  cur    <= STEP_W'(FIRST_DATA_BLOCK);
                  cnt    <= '0;
                  target <= req.block_count;
                  state  <= S_A_COUNT;
                end
              end
              OP_FREE: begin
                if (!is_data(LINK_W'(req.start_block))) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  cur   <= STEP_W'(req.start_block);
                  cnt   <= '0;
                  state <= S_F_READ;
                end
              end
              OP_LOOKUP: begin
                cur    <= STEP_W'(req.start_block);
                cnt    <= '0;
                target <= req.position;
                state  <= S_L_CHECK;
              end
              OP_FORMAT: begin
                used       <= '0;
                free_count <= MAX_FREE;
                last_slot  <= LAST_RESET;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_A_COUNT: begin
          if (cur < STEP_W'(TABLE_BLOCKS) && cnt < STEP_W'(target)) begin
            if (!used[cur_idx]) begin
              cnt <= cnt + 1'b1;
            end
            cur <= cur + 1'b1;
          end else if (cnt < STEP_W'(target)) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            cur   <= STEP_W'(FIRST_DATA_BLOCK);
            cnt   <= '0;
            state <= S_A_LINK;
          end
        end
        S_A_LINK: begin
          if (cnt == STEP_W'(target)) begin
            state <= S_A_END;
          end else begin
            if (link_hit) begin
              if (cnt == '0) begin
                first <= cur_idx;
              end else begin
                used[prev] <= 1'b1;
              end
              prev <= cur_idx;
              cnt  <= cnt + 1'b1;
            end
            cur <= cur + 1'b1;
          end
        end
        S_A_END: begin
          used[prev] <= 1'b1;
          free_count <= free_count - target;
          last_slot  <= prev;
          res_status <= ST_OK;
          res_block  <= first;
          state      <= S_DONE;
        end
        S_F_READ: begin
          state <= S_F_STEP;
        end
        S_F_STEP: begin
          used[cur_idx] <= 1'b0;
          cnt           <= cnt + 1'b1;
          if (entry == END_MARK || !is_data(entry)
              || cnt == STEP_W'(TABLE_BLOCKS - 1)) begin
            state <= S_F_FIN;
          end else begin
            cur   <= STEP_W'(entry[BLK_W-1:0]);
            state <= S_F_READ;
          end
        end
        S_F_FIN: begin
          if (free_sum > (STEP_W+1)'(MAX_FREE)) begin
            free_count <= MAX_FREE;
          end else begin
            free_count <= free_sum[BLK_W-1:0];
          end
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_L_CHECK: begin
          if (cnt == STEP_W'(target)) begin
            if (is_data(LINK_W'(cur))) begin
              res_status <= ST_OK;
              res_block  <= cur_idx;
            end else begin
              res_status <= ST_RANGE;
            end
            state <= S_DONE;
          end else if (!is_data(LINK_W'(cur))) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_L_STEP;
          end
        end
        S_L_STEP: begin
          if (entry == END_MARK) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            cur   <= STEP_W'(entry[BLK_W-1:0]);
            cnt   <= cnt + 1'b1;
            state <= S_L_CHECK;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid          <= 1'b1;
            rsp.status         <= res_status;
            rsp.block          <= res_block;
            rsp.free_blocks    <= free_count;
            rsp.last_allocated <= last_slot;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
